// File: hdl/qltu_pkg.sv
// ----------------------------------------------------------------------------
// Q-table update package
// Shared types, reset constants, register indexes and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package qltu_pkg;

   localparam logic signed [31:0] Q_INIT      = 32'sd655360;
   localparam logic signed [31:0] TDMAX_INIT  = 32'sd0;
   localparam logic signed [31:0] TDMIN_INIT  = 32'sd9830400;
   localparam logic [15:0]        GAMMA_RESET = 16'd58982;
   localparam logic [15:0]        ALPHA_RESET = 16'd6554;

   localparam int CSR_AW = 1;
   localparam logic [CSR_AW-1:0] CSR_DISCOUNT = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_LEARNING = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_GAMMA,
      ST_TD,
      ST_SCALE,
      ST_WRITE
   } fsm_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -50'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/qltu_ram.sv
// ----------------------------------------------------------------------------
// Single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qltu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 800
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire  [$clog2(DEPTH)-1:0] addr,
   input  wire  [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

`default_nettype wire

// File: hdl/q_learning_table_update.sv
// ----------------------------------------------------------------------------
// Q-learning table update
// Per-agent Q-table in one RAM; each word updates one entry and the agent's
// running td extremes.
// ----------------------------------------------------------------------------
//   Channel  Direction  Contents
//   req_     in         agent, current state, action, next state, reward
//   rsp_     out        td, largest td, smallest td, new Q value
//   csr_     in         discount factor (0), learning rate (1)
//
// A word is taken only in the idle state, after the previous word's entry has
// been written back. The next-state row and the current entry are read one at
// a time through the RAM port.
// After reset the table is cleared to 10.0, one entry a cycle, through all
// AGENTS*STATES*ACTIONS entries; req_tready stays low meanwhile.
// A result waits in the output register while the next word is accepted; the
// write-back stalls only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module q_learning_table_update
   import qltu_pkg::*;
#(
   parameter int AGENTS  = 5,
   parameter int STATES  = 32,
   parameter int ACTIONS = 5
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   // agent_index[2:0], current_state[7:3], taken_action[10:8],
   // next_state[15:11], reward_value[47:16]
   input  wire  [47:0]        req_tdata,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   // td_error[31:0], td_max[63:32], td_min[95:64], updated_value[127:96]
   output logic [127:0]       rsp_tdata,
   input  wire                csr_we,
   input  wire  [CSR_AW-1:0]  csr_addr,
   input  wire  [15:0]        csr_wdata
);

   localparam int DEPTH = AGENTS * STATES * ACTIONS;
   localparam int AW    = $clog2(DEPTH);
   localparam int AGW   = (AGENTS > 1) ? $clog2(AGENTS) : 1;
   localparam int STW   = $clog2(STATES);
   localparam int ACW   = $clog2(ACTIONS);
   localparam int CW    = $clog2(ACTIONS + 1);

   fsm_state_type state_ff, state_in;

   logic [15:0] gamma_ff, alpha_ff;

   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0] iss_cnt_ff, iss_cnt_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_pend_ff, rd_pend_in;

   logic [AGW-1:0]     ag_ff, ag_in;
   logic [AW-1:0]      row_ff, row_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic signed [31:0] reward_ff, reward_in;
   logic signed [31:0] best_ff, best_in;
   logic signed [31:0] old_ff, old_in;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [31:0] td_ff, td_in;

   logic signed [31:0] largest_ff [AGENTS];
   logic signed [31:0] smallest_ff [AGENTS];

   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_wdata;
   logic [31:0]   ram_rdata;

   logic accept, issue, commit, clr_last, iss_last;

   logic [AGW-1:0]     ag_c;
   logic [STW-1:0]     cst_c, nst_c;
   logic [ACW-1:0]     act_c;
   logic signed [31:0] nq;

   qltu_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign accept   = req_tvalid && req_tready;
   assign clr_last = (32'(clr_cnt_ff) == DEPTH - 1);
   assign iss_last = (32'(iss_cnt_ff) == ACTIONS);
   assign commit   = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      ag_c  = (32'(req_tdata[2:0]) >= AGENTS) ? AGW'(AGENTS - 1)
                                              : AGW'(req_tdata[2:0]);
      cst_c = (32'(req_tdata[7:3]) >= STATES) ? STW'(STATES - 1)
                                              : STW'(req_tdata[7:3]);
      act_c = (32'(req_tdata[10:8]) >= ACTIONS) ? ACW'(ACTIONS - 1)
                                                : ACW'(req_tdata[10:8]);
      nst_c = (32'(req_tdata[15:11]) >= STATES) ? STW'(STATES - 1)
                                                : STW'(req_tdata[15:11]);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_READ;
         ST_READ:  if (iss_last) state_in = ST_GAMMA;
         ST_GAMMA: state_in = ST_TD;
         ST_TD:    state_in = ST_SCALE;
         ST_SCALE: state_in = ST_WRITE;
         ST_WRITE: if (commit) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // Control outputs.
   assign nq = sat32(50'(old_ff) + 50'($signed(prod_ff[48:16])));

   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = cur_ff;
      ram_wdata  = nq;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_ff;
            ram_wdata = Q_INIT;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_READ: begin
            issue    = 1'b1;
            ram_addr = iss_last ? cur_ff : row_ff + AW'(iss_cnt_ff);
         end
         ST_WRITE: begin
            ram_we = commit;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      iss_cnt_in   = iss_cnt_ff;
      rd_pend_in   = issue;
      rd_idx_in    = iss_cnt_ff;
      ag_in        = ag_ff;
      row_in       = row_ff;
      cur_in       = cur_ff;
      reward_in    = reward_ff;
      best_in      = best_ff;
      old_in       = old_ff;
      prod_in      = prod_ff;
      td_in        = td_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end
      if (accept) begin
         ag_in      = ag_c;
         row_in     = AW'((int'(ag_c) * STATES + int'(nst_c)) * ACTIONS);
         cur_in     = AW'((int'(ag_c) * STATES + int'(cst_c)) * ACTIONS + int'(act_c));
         reward_in  = req_tdata[47:16];
         iss_cnt_in = '0;
      end
      if (issue) begin
         iss_cnt_in = iss_cnt_ff + CW'(1);
      end
      if (rd_pend_ff) begin
         if (32'(rd_idx_ff) == ACTIONS) begin
            old_in = ram_rdata;
         end else if (rd_idx_ff == '0 || $signed(ram_rdata) > best_ff) begin
            best_in = ram_rdata;
         end
      end
      if (state_ff == ST_GAMMA) begin
         prod_in = best_ff * $signed({1'b0, gamma_ff});
      end
      if (state_ff == ST_TD) begin
         td_in = sat32(50'(reward_ff) + 50'($signed(prod_ff[48:16])) - 50'(old_ff));
      end
      if (state_ff == ST_SCALE) begin
         prod_in = td_ff * $signed({1'b0, alpha_ff});
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {nq, smallest_ff[ag_ff], largest_ff[ag_ff], td_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         iss_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gamma_ff     <= GAMMA_RESET;
         alpha_ff     <= ALPHA_RESET;
         for (int i = 0; i < AGENTS; i++) begin
            largest_ff[i]  <= TDMAX_INIT;
            smallest_ff[i] <= TDMIN_INIT;
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         iss_cnt_ff   <= iss_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_DISCOUNT: gamma_ff <= csr_wdata;
               CSR_LEARNING: alpha_ff <= csr_wdata;
               default:      gamma_ff <= gamma_ff;
            endcase
         end
         if (state_ff == ST_SCALE) begin
            if (td_ff > largest_ff[ag_ff]) begin
               largest_ff[ag_ff] <= td_ff;
            end
            if (td_ff < smallest_ff[ag_ff]) begin
               smallest_ff[ag_ff] <= td_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      ag_ff       <= ag_in;
      row_ff      <= row_in;
      cur_ff      <= cur_in;
      reward_ff   <= reward_in;
      best_ff     <= best_in;
      old_ff      <= old_in;
      prod_ff     <= prod_in;
      td_ff       <= td_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("word accepted during table clear");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted word did not start the row read");

   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_WRITE)
      else $error("result appeared without a table write");

   a_write_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && rsp_valid_ff && !rsp_tready) |=>
         (state_ff == ST_WRITE))
      else $error("write-back overran a pending result");

endmodule

`default_nettype wire
